[rtl/bcs_pkg.sv]
// ----------------------------------------------------------------------------
// Battery charge supervisor package
// Shared types, codes and constants of the supervisor block.
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int AVG_LEN       = 64;
  localparam int AVG_SCALE_LOG = 6;
  localparam int UV_PER_MV     = 1000;
  localparam int FILL_W        = $clog2(AVG_LEN + 1);
  localparam int DIV_W         = 40;
  localparam int DSR_W         = 16;

  localparam logic [DSR_W-1:0] MV_DIVISOR = DSR_W'(UV_PER_MV << AVG_SCALE_LOG);

  localparam logic [15:0] FULL_MV      = 16'd4200;
  localparam logic [15:0] USB_ONLY_MV  = 16'd4400;
  localparam logic [15:0] OVER_MARGIN  = 16'd50;
  localparam logic [6:0]  STARTUP_HOLD = 7'd30;
  localparam logic [6:0]  FULL_HOLD    = 7'd125;
  localparam logic [6:0]  USB_HOLD     = 7'd60;
  localparam logic [6:0]  FAIL_BEEPS   = 7'd10;
  localparam logic [15:0] TIMEOUT_MV   = 16'hFFFF;
  localparam logic [15:0] MAX_MV       = 16'hFFFE;

  typedef enum logic [3:0] {
    M_IDLE        = 4'd0,
    M_STARTUP     = 4'd1,
    M_MEASURING   = 4'd2,
    M_CHARGING    = 4'd3,
    M_DISCHARGING = 4'd4,
    M_WARNING     = 4'd5,
    M_FULL        = 4'd6,
    M_DEPLETED    = 4'd7,
    M_USB         = 4'd8,
    M_OVERFULL    = 4'd9,
    M_FAIL        = 4'd10
  } mode_t;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_EXTEND   = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BEEP_NONE     = 2'd0,
    BEEP_SHUTDOWN = 2'd1,
    BEEP_FAIL     = 2'd2,
    BEEP_ALARM    = 2'd3
  } beep_t;

  typedef enum logic [2:0] {
    CFG_UV_PER_UNIT = 3'd0,
    CFG_STOP_CHARGE = 3'd1,
    CFG_DEPLETED    = 3'd2,
    CFG_LOW_WARNING = 3'd3,
    CFG_MARGIN      = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_MUL,
    C_PROD,
    C_START,
    C_DIV1,
    C_DIV2,
    C_COMMIT
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic        adc_ready;
    logic [9:0]  sample_a;
    logic [9:0]  sample_b;
    logic [9:0]  sample_c;
    logic [15:0] activity_seconds;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  supervisor_state;
    logic [15:0] filtered_mv;
    logic        relay_drive;
    logic        led_lit;
    logic [1:0]  beep_code;
    logic        alarm_drive;
    logic        restart_adc;
    logic        low_battery;
    logic [15:0] activity_left;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic prod;
    logic div1_start;
    logic div2_start;
    logic mv_load;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic sample_go;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

[rtl/bcs_if.sv]
// ----------------------------------------------------------------------------
// Supervisor channel interfaces
// Input and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        adc_ready;
  logic [9:0]  sample_a;
  logic [9:0]  sample_b;
  logic [9:0]  sample_c;
  logic [15:0] activity_seconds;

  modport source (output valid, operation, adc_ready, sample_a, sample_b, sample_c,
                  activity_seconds, input ready);
  modport sink (input valid, operation, adc_ready, sample_a, sample_b, sample_c,
                activity_seconds, output ready);
endinterface

interface bcs_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  supervisor_state;
  logic [15:0] filtered_mv;
  logic        relay_drive;
  logic        led_lit;
  logic [1:0]  beep_code;
  logic        alarm_drive;
  logic        restart_adc;
  logic        low_battery;
  logic [15:0] activity_left;

  modport source (output valid, supervisor_state, filtered_mv, relay_drive, led_lit, beep_code,
                  alarm_drive, restart_adc, low_battery, activity_left, input ready);
  modport sink (input valid, supervisor_state, filtered_mv, relay_drive, led_lit, beep_code,
                alarm_drive, restart_adc, low_battery, activity_left, output ready);
endinterface

[rtl/bcs_div.sv]
// ----------------------------------------------------------------------------
// Supervisor divider
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module bcs_div
  import bcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int STEPS = DIV_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [DIV_W-1:0] dq;
  logic [DSR_W-1:0] rem_mid, rem_next;
  logic [DIV_W-1:0] dq_next;

  function automatic logic [DSR_W:0] div_step(input logic [DSR_W-1:0] r, input logic b,
                                              input logic [DSR_W-1:0] d);
    logic [DSR_W:0] r1;
    r1 = {r, b};
    if (r1 >= {1'b0, d}) begin
      div_step = {DSR_W'(r1 - {1'b0, d}), 1'b1};
    end else begin
      div_step = {r1[DSR_W-1:0], 1'b0};
    end
  endfunction

  always_comb begin
    logic [DSR_W:0] s1, s2;
    s1 = div_step(rem, dq[DIV_W-1], dsr);
    rem_mid = s1[DSR_W:1];
    s2 = div_step(rem_mid, dq[DIV_W-2], dsr);
    rem_next = s2[DSR_W:1];
    dq_next = {dq[DIV_W-3:0], s1[0], s2[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dq  <= dq_next;
      rem <= rem_next;
    end
  end

  assign quotient = dq;

endmodule

[rtl/bcs_dp.sv]
// ----------------------------------------------------------------------------
// Supervisor datapath
// Registers, sample filter arithmetic, supervisor decisions and result word.
// ----------------------------------------------------------------------------
module bcs_dp
  import bcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  in_item_t    in_item,
  input  logic        out_ready,
  output logic        out_valid,
  output out_item_t   out_item,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat
);

  logic [15:0] uv_per_unit, stop_mv, depleted_mv, warn_mv;
  logic [9:0]  margin;

  in_item_t    item;
  logic        arith_q;
  mode_t       mode;
  logic [6:0]  hold;
  logic [15:0] meas, rep, act;
  logic        led, relay;
  logic [33:0] avg;
  logic [FILL_W-1:0] fill, fill_new;
  logic [25:0] uv;
  logic [DIV_W-1:0] prod;
  logic [17:0] mv_q;

  logic             div_start, div_done;
  logic [DIV_W-1:0] div_dividend, div_quo;
  logic [DSR_W-1:0] div_divisor;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      uv_per_unit <= 16'd5825;
      stop_mv     <= 16'd4150;
      depleted_mv <= 16'd3050;
      warn_mv     <= 16'd3500;
      margin      <= 10'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UV_PER_UNIT: uv_per_unit <= cfg_data;
        CFG_STOP_CHARGE: stop_mv     <= cfg_data;
        CFG_DEPLETED:    depleted_mv <= cfg_data;
        CFG_LOW_WARNING: warn_mv     <= cfg_data;
        CFG_MARGIN:      margin      <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic in_sampling, sampling;
  assign in_sampling = (mode >= M_STARTUP) && (mode <= M_OVERFULL);
  assign sampling    = in_sampling;
  assign stat.sample_go = (in_item.operation == OP_TICK) && in_item.adc_ready && in_sampling;

  logic [9:0] med;
  always_comb begin
    logic [9:0] lo, hi, m2;
    lo  = (item.sample_a < item.sample_b) ? item.sample_a : item.sample_b;
    hi  = (item.sample_a > item.sample_b) ? item.sample_a : item.sample_b;
    m2  = (hi < item.sample_c) ? hi : item.sample_c;
    med = (lo > m2) ? lo : m2;
  end

  // Arithmetic pipeline of the average: two products, then two divisions.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item    <= in_item;
      arith_q <= stat.sample_go;
    end
    if (cmd.mul) begin
      uv       <= 26'(med * uv_per_unit);
      fill_new <= (fill < FILL_W'(AVG_LEN)) ? fill + 1'b1 : fill;
    end
    if (cmd.prod) begin
      prod <= DIV_W'(avg * (FILL_W-1)'(fill_new - 1'b1));
    end
    if (cmd.mv_load) begin
      mv_q <= div_quo[17:0];
    end
  end

  assign div_start    = cmd.div1_start | cmd.div2_start;
  assign div_dividend = cmd.div1_start ? prod + {8'b0, uv, {AVG_SCALE_LOG{1'b0}}}
                                       : {6'b0, div_quo[33:0]};
  assign div_divisor  = cmd.div1_start ? DSR_W'(fill_new) : MV_DIVISOR;

  bcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );
  assign stat.div_done = div_done;

  // Supervisor decisions
  logic [15:0] mv_sat, meas_tick;
  logic        timeout, charged, rising, falling;
  assign mv_sat    = (mv_q > 18'(MAX_MV)) ? MAX_MV : mv_q[15:0];
  assign meas_tick = !sampling ? meas : (arith_q ? mv_sat : TIMEOUT_MV);
  assign timeout   = meas_tick == TIMEOUT_MV;
  assign charged   = (meas_tick > FULL_MV) || (meas_tick > stop_mv);
  assign rising    = {1'b0, meas_tick} > {1'b0, rep} + {7'b0, margin};
  assign falling   = {1'b0, meas_tick} + {7'b0, margin} < {1'b0, rep};

  mode_t       mode_next;
  logic [6:0]  hold_next;
  logic [15:0] meas_next, rep_next, act_next;
  logic        led_next, relay_next, alarm_next, restart_next;
  beep_t       beep_next;

  always_comb begin
    mode_next = mode;  hold_next = hold;  meas_next = meas;  rep_next = rep;
    led_next = led;  relay_next = relay;  act_next = act;
    beep_next = BEEP_NONE;  alarm_next = 1'b0;  restart_next = 1'b0;
    case (item.operation)
      OP_TICK: begin
        meas_next    = meas_tick;
        restart_next = sampling && arith_q;
        case (mode)
          M_IDLE: begin
            relay_next = 1'b1; led_next = 1'b1; restart_next = 1'b1;
            hold_next = '0; mode_next = M_STARTUP;
          end
          M_STARTUP: begin
            if (timeout) begin
              beep_next = BEEP_FAIL; rep_next = meas_tick; led_next = 1'b1;
              mode_next = M_FAIL; hold_next = '0;
            end else if (hold < STARTUP_HOLD) begin
              hold_next = hold + 1'b1;
            end else begin
              rep_next = meas_tick; led_next = 1'b0; mode_next = M_MEASURING;
              relay_next = 1'b1; hold_next = '0;
            end
          end
          M_MEASURING, M_CHARGING, M_DISCHARGING, M_WARNING: begin
            if (mode == M_WARNING) led_next = !led;
            else if (mode != M_DISCHARGING) led_next = 1'b0;
            if (timeout) begin
              beep_next = BEEP_FAIL; rep_next = meas_tick; led_next = 1'b1;
              mode_next = M_FAIL; hold_next = '0;
            end else if (charged) begin
              rep_next = meas_tick; led_next = 1'b0; mode_next = M_FULL;
              relay_next = 1'b0; hold_next = '0;
            end else if (mode == M_MEASURING) begin
              if (rising) begin
                rep_next = meas_tick; led_next = 1'b0; mode_next = M_CHARGING;
              end else if (falling) begin
                rep_next = meas_tick; led_next = 1'b0; mode_next = M_DISCHARGING;
              end
            end else if (mode == M_CHARGING) begin
              if (falling) begin
                rep_next = meas_tick; led_next = 1'b0; mode_next = M_MEASURING;
                relay_next = 1'b1; hold_next = '0;
              end else if (rising) begin
                rep_next = meas_tick;
              end
            end else if ((mode == M_DISCHARGING) && (meas_tick < warn_mv)) begin
              rep_next = meas_tick; led_next = 1'b1; mode_next = M_WARNING;
            end else if ((mode == M_WARNING) && (meas_tick < depleted_mv)) begin
              beep_next = BEEP_SHUTDOWN; rep_next = meas_tick; led_next = 1'b1;
              mode_next = M_DEPLETED; relay_next = 1'b0; hold_next = '0;
            end else if (act == 16'd0) begin
              beep_next = BEEP_SHUTDOWN; rep_next = meas_tick; led_next = 1'b0;
              mode_next = M_DEPLETED; relay_next = 1'b0; hold_next = '0;
            end else if (rising) begin
              rep_next = meas_tick; led_next = 1'b0; mode_next = M_MEASURING;
              relay_next = 1'b1; hold_next = '0;
            end else if ((mode == M_DISCHARGING) && falling) begin
              rep_next = meas_tick;
            end
          end
          M_FULL: begin
            relay_next = 1'b0;
            if (timeout) begin
              beep_next = BEEP_FAIL; rep_next = meas_tick; led_next = 1'b1;
              mode_next = M_FAIL; hold_next = '0;
            end else if (meas_tick > USB_ONLY_MV) begin
              rep_next = meas_tick; led_next = 1'b0; mode_next = M_USB; hold_next = USB_HOLD;
            end else if (hold < FULL_HOLD) begin
              hold_next = hold + 1'b1;
            end else if ({1'b0, meas_tick} > {1'b0, rep} + {1'b0, OVER_MARGIN}) begin
              rep_next = meas_tick; led_next = 1'b1; mode_next = M_OVERFULL;
            end
          end
          M_DEPLETED, M_USB: begin
            if (mode == M_DEPLETED) led_next = !led;
            relay_next = 1'b0;
            if (timeout) begin
              beep_next = BEEP_FAIL; rep_next = meas_tick; led_next = 1'b1;
              mode_next = M_FAIL; hold_next = '0;
            end
          end
          M_OVERFULL: begin
            relay_next = 1'b0; rep_next = meas_tick;
            beep_next = BEEP_ALARM; alarm_next = 1'b1; led_next = !led;
          end
          default: begin
            led_next = !led; relay_next = 1'b0;
            if (hold < FAIL_BEEPS) begin
              beep_next = BEEP_FAIL; hold_next = hold + 1'b1;
            end else begin
              rep_next = meas; led_next = 1'b1; restart_next = 1'b1; mode_next = M_IDLE;
            end
          end
        endcase
        if (act != 16'd0) act_next = act - 1'b1;
      end
      OP_EXTEND: begin
        if (act < item.activity_seconds) act_next = item.activity_seconds;
      end
      OP_CLEAR: act_next = 16'd0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= M_IDLE;
      hold  <= '0;
      meas  <= '0;
      rep   <= '0;
      avg   <= '0;
      fill  <= '0;
      act   <= '0;
      led   <= 1'b0;
      relay <= 1'b1;
    end else begin
      if (cmd.div2_start) begin
        avg  <= div_quo[33:0];
        fill <= fill_new;
      end
      if (cmd.commit) begin
        mode  <= mode_next;
        hold  <= hold_next;
        meas  <= meas_next;
        rep   <= rep_next;
        act   <= act_next;
        led   <= led_next;
        relay <= relay_next;
      end
    end
  end

  // Result register: holds a finished word while the next item is taken in.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item.supervisor_state <= mode_next;
      out_item.filtered_mv      <= meas_next;
      out_item.relay_drive      <= relay_next;
      out_item.led_lit          <= led_next;
      out_item.beep_code        <= beep_next;
      out_item.alarm_drive      <= alarm_next;
      out_item.restart_adc      <= restart_next;
      out_item.low_battery      <= mode_next == M_WARNING;
      out_item.activity_left    <= act_next;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  a_commit_free : assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready)) else $error("result word overwritten");
  a_commit_valid : assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid) else $error("committed word not presented");
  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(AVG_LEN)) else $error("average fill count overrun");
  a_no_false_timeout : assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && arith_q && (item.operation == OP_TICK)) |=> (meas != TIMEOUT_MV))
    else $error("converted sample reads as timeout");

endmodule

[rtl/bcs_ctrl.sv]
// ----------------------------------------------------------------------------
// Supervisor controller
// Sequences acceptance, multiplications, divisions and commit of one word.
// ----------------------------------------------------------------------------
module bcs_ctrl
  import bcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = stat.sample_go ? C_MUL : C_COMMIT;
        end
      end
      C_MUL: begin
        cmd.mul    = 1'b1;
        state_next = C_PROD;
      end
      C_PROD: begin
        cmd.prod   = 1'b1;
        state_next = C_START;
      end
      C_START: begin
        cmd.div1_start = 1'b1;
        state_next     = C_DIV1;
      end
      C_DIV1: begin
        if (stat.div_done) begin
          cmd.div2_start = 1'b1;
          state_next     = C_DIV2;
        end
      end
      C_DIV2: begin
        if (stat.div_done) begin
          cmd.mv_load = 1'b1;
          state_next  = C_COMMIT;
        end
      end
      C_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

  a_one_start : assert property (@(posedge clk) disable iff (rst)
    !(cmd.div1_start && cmd.div2_start)) else $error("two divisions started at once");
  a_accept_idle : assert property (@(posedge clk) disable iff (rst)
    cmd.accept |-> $past(cmd.commit) || (state == C_IDLE)) else $error("word taken while busy");
  a_commit_done : assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (state == C_IDLE)) else $error("controller did not return to idle");

endmodule

[rtl/battery_charge_supervisor_unit.sv]
// ----------------------------------------------------------------------------
// Battery charge supervisor
// Lithium battery supervisor: median, average, state machine and timers.
// ----------------------------------------------------------------------------
//  channel     dir   handshake     word
//  item_in     in    valid/ready   operation, adc_ready, three samples, seconds
//  result_out  out   valid/ready   state, millivolts, drives, activity left
//  cfg         in    cfg_we        cfg_index selects register, cfg_data value
//
// A tick with a converted sample passes, after acceptance, the multiply states C_MUL and
// C_PROD, a start state, two passes of the shared two-bit-per-cycle divider (20 steps
// each) and a commit state that waits for a free result register. Other words go from
// acceptance straight to the commit state; after a commit the next word can be taken.
// Reset is synchronous; it clears the filter, timers and state machine.
// A stalled result is held in its register while the next word is accepted.
// ----------------------------------------------------------------------------
module battery_charge_supervisor_unit
  import bcs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  bcs_in_if.sink       item_in,
  bcs_out_if.source    result_out
);

  in_item_t  in_item;
  out_item_t out_item;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  logic      out_valid;

  assign in_item.operation        = item_in.operation;
  assign in_item.adc_ready        = item_in.adc_ready;
  assign in_item.sample_a         = item_in.sample_a;
  assign in_item.sample_b         = item_in.sample_b;
  assign in_item.sample_c         = item_in.sample_c;
  assign in_item.activity_seconds = item_in.activity_seconds;

  bcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .in_ready (item_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bcs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_ready (result_out.ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

  assign result_out.valid            = out_valid;
  assign result_out.supervisor_state = out_item.supervisor_state;
  assign result_out.filtered_mv      = out_item.filtered_mv;
  assign result_out.relay_drive      = out_item.relay_drive;
  assign result_out.led_lit          = out_item.led_lit;
  assign result_out.beep_code        = out_item.beep_code;
  assign result_out.alarm_drive      = out_item.alarm_drive;
  assign result_out.restart_adc      = out_item.restart_adc;
  assign result_out.low_battery      = out_item.low_battery;
  assign result_out.activity_left    = out_item.activity_left;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery charge supervisor testbench
// Drives ticks, activity words and ignored codes through the supervisor with
// random idling on both channels, predicts every result word in the bench and
// compares each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import bcs_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  bcs_in_if  item_ch ();
  bcs_out_if result_ch ();

  battery_charge_supervisor_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_in    (item_ch.sink),
    .result_out (result_ch.source)
  );

  // Bench copy of the calibration and thresholds.
  logic [15:0] uv_per_unit, stop_charge, depleted_lvl, low_warn, margin;

  // Bench copy of the supervisor state.
  mode_t       sup_mode;
  logic [6:0]  hold_cnt;
  logic [15:0] meas_mv, rep_mv, act_left;
  logic [63:0] avg_acc;
  int unsigned avg_fill;
  logic        led_q, relay_q;
  logic [1:0]  beep_now;
  logic        alarm_now, restart_now;

  in_item_t  pending_words[$];
  out_item_t expected_results[$];

  int  send_idle, recv_idle;
  int  stall_left;
  int  fail_count;
  int  walk_lvl;
  bit  word_taken;

  always #5 clk = ~clk;

  function automatic logic [9:0] med3(logic [9:0] a, logic [9:0] b, logic [9:0] c);
    logic [9:0] lo, hi;
    lo = (a < b) ? a : b;
    hi = (a > b) ? a : b;
    hi = (hi < c) ? hi : c;
    return (lo > hi) ? lo : hi;
  endfunction

  task automatic filter_sample(logic rdy, logic [9:0] a, logic [9:0] b, logic [9:0] c);
    logic [31:0] uv;
    logic [63:0] scaled, mv;
    if (!rdy) begin
      meas_mv = TIMEOUT_MV;
      return;
    end
    restart_now = 1'b1;
    uv = 32'(med3(a, b, c)) * 32'(uv_per_unit);
    scaled = 64'(uv) * 64'd64;
    if (avg_fill < AVG_LEN) begin
      avg_fill++;
      avg_acc = (avg_acc * 64'(avg_fill - 1) + scaled) / 64'(avg_fill);
    end else begin
      avg_acc = (avg_acc * 64'(AVG_LEN - 1) + scaled) / 64'(AVG_LEN);
    end
    mv = avg_acc / 64'd64 / 64'd1000;
    meas_mv = (mv > 64'(MAX_MV)) ? MAX_MV : mv[15:0];
  endtask

  function automatic bit is_charged();
    return meas_mv > FULL_MV || meas_mv > stop_charge;
  endfunction

  function automatic bit is_rising();
    return 32'(meas_mv) > 32'(rep_mv) + 32'(margin);
  endfunction

  function automatic bit is_falling();
    return 32'(meas_mv) + 32'(margin) < 32'(rep_mv);
  endfunction

  task automatic enter(mode_t m, logic l);
    rep_mv = meas_mv;
    led_q = l;
    sup_mode = m;
  endtask

  task automatic enter_full();
    enter(M_FULL, 1'b0); relay_q = 1'b0; hold_cnt = '0;
  endtask

  task automatic enter_measuring();
    enter(M_MEASURING, 1'b0); relay_q = 1'b1; hold_cnt = '0;
  endtask

  task automatic go_fault();
    beep_now = BEEP_FAIL; enter(M_FAIL, 1'b1); hold_cnt = '0;
  endtask

  task automatic enter_off(logic l);
    beep_now = BEEP_SHUTDOWN; enter(M_DEPLETED, l); relay_q = 1'b0; hold_cnt = '0;
  endtask

  task automatic run_tick(in_item_t w);
    case (sup_mode)
      M_IDLE: begin
        relay_q = 1'b1; led_q = 1'b1; restart_now = 1'b1;
        hold_cnt = '0; sup_mode = M_STARTUP;
      end
      M_STARTUP: begin
        filter_sample(w.adc_ready, w.sample_a, w.sample_b, w.sample_c);
        if (meas_mv == TIMEOUT_MV) go_fault();
        else if (hold_cnt < STARTUP_HOLD) hold_cnt++;
        else enter_measuring();
      end
      M_MEASURING: begin
        filter_sample(w.adc_ready, w.sample_a, w.sample_b, w.sample_c);
        led_q = 1'b0;
        if (meas_mv == TIMEOUT_MV) go_fault();
        else if (is_charged()) enter_full();
        else if (is_rising()) enter(M_CHARGING, 1'b0);
        else if (is_falling()) enter(M_DISCHARGING, 1'b0);
      end
      M_CHARGING: begin
        filter_sample(w.adc_ready, w.sample_a, w.sample_b, w.sample_c);
        led_q = 1'b0;
        if (meas_mv == TIMEOUT_MV) go_fault();
        else if (is_charged()) enter_full();
        else if (is_falling()) enter_measuring();
        else if (is_rising()) rep_mv = meas_mv;
      end
      M_DISCHARGING: begin
        filter_sample(w.adc_ready, w.sample_a, w.sample_b, w.sample_c);
        if (meas_mv == TIMEOUT_MV) go_fault();
        else if (is_charged()) enter_full();
        else if (meas_mv < low_warn) enter(M_WARNING, 1'b1);
        else if (act_left == 0) enter_off(1'b0);
        else if (is_rising()) enter_measuring();
        else if (is_falling()) rep_mv = meas_mv;
      end
      M_WARNING: begin
        led_q = ~led_q;
        filter_sample(w.adc_ready, w.sample_a, w.sample_b, w.sample_c);
        if (meas_mv == TIMEOUT_MV) go_fault();
        else if (is_charged()) enter_full();
        else if (meas_mv < depleted_lvl) enter_off(1'b1);
        else if (act_left == 0) enter_off(1'b0);
        else if (is_rising()) enter_measuring();
      end
      M_FULL: begin
        relay_q = 1'b0;
        filter_sample(w.adc_ready, w.sample_a, w.sample_b, w.sample_c);
        if (meas_mv == TIMEOUT_MV) go_fault();
        else if (meas_mv > USB_ONLY_MV) begin
          enter(M_USB, 1'b0); hold_cnt = USB_HOLD;
        end
        else if (hold_cnt < FULL_HOLD) hold_cnt++;
        else if (32'(meas_mv) > 32'(rep_mv) + 32'(OVER_MARGIN)) enter(M_OVERFULL, 1'b1);
      end
      M_DEPLETED: begin
        led_q = ~led_q; relay_q = 1'b0;
        filter_sample(w.adc_ready, w.sample_a, w.sample_b, w.sample_c);
        if (meas_mv == TIMEOUT_MV) go_fault();
      end
      M_USB: begin
        relay_q = 1'b0;
        filter_sample(w.adc_ready, w.sample_a, w.sample_b, w.sample_c);
        if (meas_mv == TIMEOUT_MV) go_fault();
      end
      M_OVERFULL: begin
        // The alarm state is a sink: no timeout check, the alarm repeats.
        relay_q = 1'b0;
        filter_sample(w.adc_ready, w.sample_a, w.sample_b, w.sample_c);
        rep_mv = meas_mv;
        beep_now = BEEP_ALARM; alarm_now = 1'b1;
        led_q = ~led_q;
      end
      default: begin
        led_q = ~led_q; relay_q = 1'b0;
        if (hold_cnt < FAIL_BEEPS) begin
          beep_now = BEEP_FAIL;
          hold_cnt++;
        end else begin
          rep_mv = meas_mv;
          led_q = 1'b1; restart_now = 1'b1;
          sup_mode = M_IDLE;
        end
      end
    endcase
    if (act_left > 0) act_left--;
  endtask

  task automatic predict_supervisor(in_item_t w, output out_item_t r);
    beep_now = BEEP_NONE; alarm_now = 1'b0; restart_now = 1'b0;
    case (w.operation)
      OP_TICK:   run_tick(w);
      OP_EXTEND: if (act_left < w.activity_seconds) act_left = w.activity_seconds;
      OP_CLEAR:  act_left = '0;
      default: ;
    endcase
    r.supervisor_state = sup_mode;
    r.filtered_mv      = meas_mv;
    r.relay_drive      = relay_q;
    r.led_lit          = led_q;
    r.beep_code        = beep_now;
    r.alarm_drive      = alarm_now;
    r.restart_adc      = restart_now;
    r.low_battery      = (sup_mode == M_WARNING);
    r.activity_left    = act_left;
  endtask

  task automatic push_word(logic [1:0] op, logic rdy, logic [9:0] a, logic [9:0] b,
                           logic [9:0] c, logic [15:0] secs);
    in_item_t w;
    w.operation = op; w.adc_ready = rdy;
    w.sample_a = a; w.sample_b = b; w.sample_c = c;
    w.activity_seconds = secs;
    pending_words.push_back(w);
  endtask

  function automatic logic [9:0] near_lvl();
    int v;
    v = walk_lvl + $urandom_range(4) - 2;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[9:0];
  endfunction

  // Mostly ticks whose samples follow a slowly drifting battery level, so the
  // state machine gets well past startup; the rest are activity words and noise.
  task automatic push_random(int n);
    int r;
    logic [9:0] a, b, c;
    logic [15:0] secs;
    repeat (n) begin
      r = $urandom_range(99);
      secs = $urandom_range(1) ? 16'($urandom_range(200)) : 16'($urandom);
      if (r < 5) begin
        push_word(OP_EXTEND, 1'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                  secs);
      end else if (r < 7) begin
        push_word(OP_CLEAR, 1'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                  16'($urandom));
      end else if (r < 8) begin
        push_word(OP_RESERVED, 1'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                  16'($urandom));
      end else if (r < 13) begin
        push_word(OP_TICK, $urandom_range(99) >= 2, 10'($urandom), 10'($urandom),
                  10'($urandom), 16'($urandom));
      end else begin
        if ($urandom_range(99) < 2) walk_lvl = $urandom_range(800, 450);
        else walk_lvl += $urandom_range(6) - 3;
        if (walk_lvl < 400) walk_lvl = 400;
        if (walk_lvl > 850) walk_lvl = 850;
        a = near_lvl(); b = near_lvl(); c = near_lvl();
        if ($urandom_range(9) == 0) b = 10'($urandom);
        push_word(OP_TICK, $urandom_range(99) >= 2, a, b, c, 16'($urandom));
      end
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
    case (idx)
      CFG_UV_PER_UNIT: uv_per_unit  = val;
      CFG_STOP_CHARGE: stop_charge  = val;
      CFG_DEPLETED:    depleted_lvl = val;
      CFG_LOW_WARNING: low_warn     = val;
      default:         margin       = {6'd0, val[9:0]};
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(logic [15:0] uv, logic [15:0] stop, logic [15:0] dep,
                           logic [15:0] warn, logic [15:0] mrg);
    write_reg(CFG_UV_PER_UNIT, uv);
    write_reg(CFG_STOP_CHARGE, stop);
    write_reg(CFG_DEPLETED, dep);
    write_reg(CFG_LOW_WARNING, warn);
    write_reg(CFG_MARGIN, mrg);
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !item_ch.valid && expected_results.size() == 0);
    repeat (60) @(negedge clk);
  endtask

  // Acceptance of an input word: predict its result at the same edge.
  always @(posedge clk) begin
    out_item_t r;
    word_taken = !rst && item_ch.valid && item_ch.ready;
    if (word_taken) begin
      predict_supervisor({item_ch.operation, item_ch.adc_ready, item_ch.sample_a,
                          item_ch.sample_b, item_ch.sample_c, item_ch.activity_seconds}, r);
      expected_results.push_back(r);
    end
  end

  always @(negedge clk) begin
    in_item_t w;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || word_taken) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
        w = pending_words.pop_front();
        item_ch.operation        <= w.operation;
        item_ch.adc_ready        <= w.adc_ready;
        item_ch.sample_a         <= w.sample_a;
        item_ch.sample_b         <= w.sample_b;
        item_ch.sample_c         <= w.sample_c;
        item_ch.activity_seconds <= w.activity_seconds;
        item_ch.valid            <= 1'b1;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    result_ch.ready <= !rst && stall_left == 0 && $urandom_range(99) >= recv_idle;
  end

  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with no prediction waiting");
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (result_ch.supervisor_state !== e.supervisor_state) begin
          $error("supervisor_state expected %0d actual %0d", e.supervisor_state,
                 result_ch.supervisor_state);
          fail_count++;
        end
        if (result_ch.filtered_mv !== e.filtered_mv) begin
          $error("filtered_mv expected %0d actual %0d", e.filtered_mv, result_ch.filtered_mv);
          fail_count++;
        end
        if (result_ch.relay_drive !== e.relay_drive) begin
          $error("relay_drive expected %0d actual %0d", e.relay_drive, result_ch.relay_drive);
          fail_count++;
        end
        if (result_ch.led_lit !== e.led_lit) begin
          $error("led_lit expected %0d actual %0d", e.led_lit, result_ch.led_lit);
          fail_count++;
        end
        if (result_ch.beep_code !== e.beep_code) begin
          $error("beep_code expected %0d actual %0d", e.beep_code, result_ch.beep_code);
          fail_count++;
        end
        if (result_ch.alarm_drive !== e.alarm_drive) begin
          $error("alarm_drive expected %0d actual %0d", e.alarm_drive, result_ch.alarm_drive);
          fail_count++;
        end
        if (result_ch.restart_adc !== e.restart_adc) begin
          $error("restart_adc expected %0d actual %0d", e.restart_adc, result_ch.restart_adc);
          fail_count++;
        end
        if (result_ch.low_battery !== e.low_battery) begin
          $error("low_battery expected %0d actual %0d", e.low_battery, result_ch.low_battery);
          fail_count++;
        end
        if (result_ch.activity_left !== e.activity_left) begin
          $error("activity_left expected %0d actual %0d", e.activity_left,
                 result_ch.activity_left);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    clk = 1'b0; rst = 1'b1;
    cfg_we = 1'b0; cfg_index = CFG_UV_PER_UNIT; cfg_data = '0;
    item_ch.valid = 1'b0; item_ch.operation = OP_TICK; item_ch.adc_ready = 1'b0;
    item_ch.sample_a = '0; item_ch.sample_b = '0; item_ch.sample_c = '0;
    item_ch.activity_seconds = '0;
    result_ch.ready = 1'b0;
    uv_per_unit = 16'd5825; stop_charge = 16'd4150; depleted_lvl = 16'd3050;
    low_warn = 16'd3500; margin = 16'd20;
    sup_mode = M_IDLE; hold_cnt = '0; meas_mv = '0; rep_mv = '0; act_left = '0;
    avg_acc = '0; avg_fill = 0; led_q = 1'b0; relay_q = 1'b1;
    stall_left = 0; fail_count = 0; walk_lvl = 600; word_taken = 1'b0;
    send_idle = 36; recv_idle = 46;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: activity extremes, an ignored code, sample extremes and a
    // converter timeout that runs the whole fail sequence back to idle.
    push_word(OP_EXTEND, 1'b0, '0, '0, '0, 16'hFFFF);
    push_word(OP_EXTEND, 1'b1, '0, '0, '0, 16'h0000);
    push_word(OP_CLEAR, 1'b1, 10'h3FF, 10'h3FF, 10'h3FF, 16'hFFFF);
    push_word(OP_RESERVED, 1'b1, 10'h3FF, 10'h3FF, 10'h3FF, 16'hFFFF);
    push_word(OP_TICK, 1'b1, 10'd0, 10'd0, 10'd0, 16'd0);
    push_word(OP_TICK, 1'b1, 10'd0, 10'd1023, 10'd512, 16'd0);
    push_word(OP_TICK, 1'b1, 10'd1023, 10'd1023, 10'd1023, 16'd0);
    push_word(OP_TICK, 1'b1, 10'd0, 10'd0, 10'd0, 16'd0);
    push_word(OP_TICK, 1'b0, 10'd600, 10'd600, 10'd600, 16'd0);
    repeat (12) push_word(OP_TICK, 1'b1, 10'd600, 10'd601, 10'd599, 16'd0);
    push_word(OP_EXTEND, 1'b0, '0, '0, '0, 16'd300);
    push_random(640);
    drain();

    // Extreme calibration: saturated millivolts and a wide margin.
    write_all(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h03FF);
    send_idle = 46; recv_idle = 36;
    push_random(300);
    drain();

    // Zero calibration, charge stop and margin at zero, depletion and warning levels at their top.
    write_all(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_idle = 0; recv_idle = 0;
    push_random(250);
    drain();

    write_all(16'd5825 + 16'($urandom_range(200)) - 16'd100, 16'd4100 + 16'($urandom_range(100)),
              16'd3000 + 16'($urandom_range(100)), 16'd3450 + 16'($urandom_range(100)),
              16'($urandom_range(40)));
    push_random(730);
    // Hold results back long enough for the block to stall its input.
    @(negedge clk);
    stall_left = 500;
    drain();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/bcs_pkg.sv
rtl/bcs_if.sv
rtl/bcs_div.sv
rtl/bcs_dp.sv
rtl/bcs_ctrl.sv
rtl/battery_charge_supervisor_unit.sv
bench/tb_top.sv
